// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL that checks itself.
// Both are sampled on the rising edge of aclk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define PPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define PPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/ppc_pkg.sv -----
package ppc_pkg;

    // Field widths.
    localparam int POS_W  = 32;
    localparam int HEAD_W = 16;

    // Working width of the rotated vector (Q16.32, with CORDIC growth).
    localparam int XY_W  = 50;
    // Residual angle width, in units of 2^-32 turn.
    localparam int Z_W   = 34;
    // Width of a rotated coordinate after rounding back to Q16.16.
    localparam int RES_W = XY_W - 16;

    // Longest micro-rotation chain that the angle table supports.
    localparam int MAX_STAGES = 24;

    // Inverse CORDIC gain, 0.6072529350 in Q31.
    localparam logic signed [31:0] GAIN_Q31 = 32'sd1304065748;

    // atan(2^-i) / (2 pi) * 2^32, rounded to nearest.
    localparam logic [30:0] ATAN_TURNS [MAX_STAGES] = '{
        31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756,
        31'd42667331,  31'd21354465,  31'd10679838,  31'd5340245,
        31'd2670163,   31'd1335087,   31'd667544,    31'd333772,
        31'd166886,    31'd83443,     31'd41722,     31'd20861,
        31'd10430,     31'd5215,      31'd2608,      31'd1304,
        31'd652,       31'd326,       31'd163,       31'd81
    };

    // Request kinds.
    typedef enum logic {
        REQ_COMPOSE = 1'b0,
        REQ_EXPRESS = 1'b1
    } req_type_t;

    // Payload that walks down the rotation chain.
    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic signed [POS_W-1:0]  ox;
        logic signed [POS_W-1:0]  oy;
        logic        [HEAD_W-1:0] heading;
    } rot_t;

    // Stage handshake between neighbors: advance strobe and the item's valid.
    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

// ----- rtl/planar_pose_compose.sv -----
// Planar pose composition, fixed point.
// Input stream: s_tdata carries pose a (ax, ay, a_heading) and pose b
// (bx, by, b_heading); s_tuser selects the request kind. Kind 0 maps a
// from the frame of b into global coordinates, kind 1 expresses a in the
// frame of b. Positions are Q16.16, headings are 16-bit binary angles.
// Output stream: m_tdata carries cx, cy and c_heading; m_tuser flags that
// a position was clamped to 32 bits. The heading wraps and never clamps.
// The pipeline holds three front-end registers (operands, gain multiply,
// angle fold), one cell per micro-rotation, then rounding and the output
// register. Throughput is one request per cycle while the receiver does
// not stall; the rotation chain holds one request per cell, so up to
// NUM_CELLS + 5 requests are in flight, with NUM_CELLS capped at MAX_STAGES.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops; it rises again as soon as the result is taken.
// Reset clears every valid bit; data in flight is dropped.
module planar_pose_compose
    import ppc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ax[31:0], ay[63:32], a_heading[79:64], bx[111:80], by[143:112],
    // b_heading[159:144]
    input  logic [159:0] s_tdata,
    // req_type[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // cx[31:0], cy[63:32], c_heading[79:64]
    output logic [79:0]  m_tdata,
    // overflow[0]
    output logic [0:0]   m_tuser
);

    localparam int NUM_CELLS = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;

    logic       en;
    stage_ctl_t in_ctl;
    logic       cell_valid [NUM_CELLS+1];
    rot_t       cell_data  [NUM_CELLS+1];
    stage_ctl_t cell_ctl   [NUM_CELLS+1];

    logic signed [POS_W-1:0]  cx, cy;
    logic        [HEAD_W-1:0] c_heading;
    logic                     overflow;

    // The pipeline advances unless a result waits for a stalled receiver.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign in_ctl   = '{en: en, valid: s_tvalid};

    // Operand selection, gain and angle fold.
    ppc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (in_ctl),
        .req_type  (s_tuser[0]),
        .ax        (s_tdata[31:0]),
        .ay        (s_tdata[63:32]),
        .a_heading (s_tdata[79:64]),
        .bx        (s_tdata[111:80]),
        .by        (s_tdata[143:112]),
        .b_heading (s_tdata[159:144]),
        .valid_out (cell_valid[0]),
        .data_out  (cell_data[0])
    );

    // Chain of micro-rotation cells.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        assign cell_ctl[i] = '{en: en, valid: cell_valid[i]};

        ppc_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl_in    (cell_ctl[i]),
            .data_in   (cell_data[i]),
            .valid_out (cell_valid[i+1]),
            .data_out  (cell_data[i+1])
        );
    end

    assign cell_ctl[NUM_CELLS] = '{en: en, valid: cell_valid[NUM_CELLS]};

    // Rounding, offset, saturation and the output register.
    ppc_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_in    (cell_ctl[NUM_CELLS]),
        .data_in   (cell_data[NUM_CELLS]),
        .valid_out (m_tvalid),
        .cx        (cx),
        .cy        (cy),
        .c_heading (c_heading),
        .overflow  (overflow)
    );

    assign m_tdata = {c_heading, cy, cx};
    assign m_tuser = overflow;

    // Checks on the pipeline control and the clamp flag.
    logic cx_rail, cy_rail;
    assign cx_rail = (cx == {1'b0, {(POS_W-1){1'b1}}}) || (cx == {1'b1, {(POS_W-1){1'b0}}});
    assign cy_rail = (cy == {1'b0, {(POS_W-1){1'b1}}}) || (cy == {1'b1, {(POS_W-1){1'b0}}});

`include "assert_macros.svh"

    `PPC_ASSERT(a_stall_blocks_input, (m_tvalid && !m_tready) |-> !s_tready, "input taken while output stalled")
    `PPC_ASSERT(a_overflow_on_rail, (m_tvalid && overflow) |-> (cx_rail || cy_rail), "overflow without a clamped coordinate")
    `PPC_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule

// ----- rtl/ppc_prep.sv -----
module ppc_prep
    import ppc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  stage_ctl_t               ctl_in,
    input  logic                     req_type,
    input  logic signed [POS_W-1:0]  ax,
    input  logic signed [POS_W-1:0]  ay,
    input  logic signed [HEAD_W-1:0] a_heading,
    input  logic signed [POS_W-1:0]  bx,
    input  logic signed [POS_W-1:0]  by,
    input  logic signed [HEAD_W-1:0] b_heading,
    output logic                     valid_out,
    output rot_t                     data_out
);

    // Stage A registers: vector to rotate, angle, offset and heading.
    logic                      a_valid_reg;
    logic signed [POS_W:0]     vx_a_reg, vy_a_reg, vx_a_next, vy_a_next;
    logic signed [HEAD_W-1:0]  t_a_reg, t_a_next;
    logic signed [POS_W-1:0]   ox_a_reg, oy_a_reg, ox_a_next, oy_a_next;
    logic        [HEAD_W-1:0]  head_a_reg, head_a_next;

    // Stage B registers: gain products.
    logic                      b_valid_reg;
    logic signed [2*POS_W:0]   px_b_reg, py_b_reg, px_b_next, py_b_next;
    logic signed [HEAD_W-1:0]  t_b_reg;
    logic signed [POS_W-1:0]   ox_b_reg, oy_b_reg;
    logic        [HEAD_W-1:0]  head_b_reg;

    // Stage C registers: folded vector and residual angle.
    logic                      c_valid_reg;
    rot_t                      c_reg, c_next;

    logic signed [2*POS_W:0]   px_rnd, py_rnd;
    logic signed [XY_W-1:0]    xs_rnd, ys_rnd;
    logic                      fold;
    logic signed [HEAD_W-1:0]  t_fold;

    // Operand selection per request kind; the heading wraps modulo one turn.
    always_comb begin
        if (req_type_t'(req_type) == REQ_EXPRESS) begin
            vx_a_next   = {ax[POS_W-1], ax} - {bx[POS_W-1], bx};
            vy_a_next   = {ay[POS_W-1], ay} - {by[POS_W-1], by};
            t_a_next    = HEAD_W'(0 - b_heading);
            ox_a_next   = '0;
            oy_a_next   = '0;
            head_a_next = HEAD_W'(a_heading - b_heading);
        end else begin
            vx_a_next   = {ax[POS_W-1], ax};
            vy_a_next   = {ay[POS_W-1], ay};
            t_a_next    = b_heading;
            ox_a_next   = bx;
            oy_a_next   = by;
            head_a_next = HEAD_W'(a_heading + b_heading);
        end
    end

    // Scale by the inverse CORDIC gain.
    assign px_b_next = vx_a_reg * GAIN_Q31;
    assign py_b_next = vy_a_reg * GAIN_Q31;

    // Round the products to Q16.32 and fold the angle into half a turn.
    always_comb begin
        px_rnd = (px_b_reg + (2*POS_W+1)'(16384)) >>> 15;
        py_rnd = (py_b_reg + (2*POS_W+1)'(16384)) >>> 15;
        xs_rnd = px_rnd[XY_W-1:0];
        ys_rnd = py_rnd[XY_W-1:0];
        fold   = (t_b_reg > 16'sd16384) || (t_b_reg < -16'sd16384);
        // Moving by half a turn in either direction flips the sign bit.
        t_fold = {~t_b_reg[HEAD_W-1], t_b_reg[HEAD_W-2:0]};

        c_next.x       = fold ? -xs_rnd : xs_rnd;
        c_next.y       = fold ? -ys_rnd : ys_rnd;
        c_next.z       = fold ? {{(Z_W-32){t_fold[HEAD_W-1]}}, t_fold, 16'd0}
                              : {{(Z_W-32){t_b_reg[HEAD_W-1]}}, t_b_reg, 16'd0};
        c_next.ox      = ox_b_reg;
        c_next.oy      = oy_b_reg;
        c_next.heading = head_b_reg;
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else if (ctl_in.en) begin
            a_valid_reg <= ctl_in.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            vx_a_reg   <= vx_a_next;
            vy_a_reg   <= vy_a_next;
            t_a_reg    <= t_a_next;
            ox_a_reg   <= ox_a_next;
            oy_a_reg   <= oy_a_next;
            head_a_reg <= head_a_next;

            px_b_reg   <= px_b_next;
            py_b_reg   <= py_b_next;
            t_b_reg    <= t_a_reg;
            ox_b_reg   <= ox_a_reg;
            oy_b_reg   <= oy_a_reg;
            head_b_reg <= head_a_reg;

            c_reg      <= c_next;
        end
    end

    assign valid_out = c_valid_reg;
    assign data_out  = c_reg;

endmodule

// ----- rtl/ppc_cordic_cell.sv -----
module ppc_cordic_cell
    import ppc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  stage_ctl_t ctl_in,
    input  rot_t       data_in,
    output logic       valid_out,
    output rot_t       data_out
);

    logic              valid_reg;
    rot_t              data_reg, data_next;
    logic signed [XY_W-1:0] xs, ys;
    logic signed [Z_W-1:0]  step;

    // One micro-rotation, direction chosen by the sign of the residual angle.
    always_comb begin
        xs   = $signed(data_in.x) >>> STAGE;
        ys   = $signed(data_in.y) >>> STAGE;
        step = $signed({{(Z_W-31){1'b0}}, ATAN_TURNS[STAGE]});
        data_next = data_in;
        if (!data_in.z[Z_W-1]) begin
            data_next.x = data_in.x - ys;
            data_next.y = data_in.y + xs;
            data_next.z = data_in.z - step;
        end else begin
            data_next.x = data_in.x + ys;
            data_next.y = data_in.y - xs;
            data_next.z = data_in.z + step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl_in.en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

// ----- rtl/ppc_post.sv -----
module ppc_post
    import ppc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  stage_ctl_t               ctl_in,
    input  rot_t                     data_in,
    output logic                     valid_out,
    output logic signed [POS_W-1:0]  cx,
    output logic signed [POS_W-1:0]  cy,
    output logic        [HEAD_W-1:0] c_heading,
    output logic                     overflow
);

    // Stage D registers: coordinates rounded back to Q16.16.
    logic                     d_valid_reg;
    logic signed [RES_W-1:0]  rx_d_reg, ry_d_reg, rx_d_next, ry_d_next;
    logic signed [POS_W-1:0]  ox_d_reg, oy_d_reg;
    logic        [HEAD_W-1:0] head_d_reg;

    // Output registers.
    logic                     out_valid_reg;
    logic signed [POS_W-1:0]  cx_reg, cy_reg, cx_next, cy_next;
    logic        [HEAD_W-1:0] head_reg;
    logic                     ovf_reg, ovf_next;

    logic signed [XY_W-1:0]   x_rnd, y_rnd;
    logic signed [RES_W:0]    sum_x, sum_y;
    logic                     sat_x, sat_y;

    // Round half up from Q16.32 to Q16.16.
    always_comb begin
        x_rnd     = data_in.x + XY_W'(32768);
        y_rnd     = data_in.y + XY_W'(32768);
        rx_d_next = x_rnd[XY_W-1:16];
        ry_d_next = y_rnd[XY_W-1:16];
    end

    // Add the offset of frame b and clamp to 32 bits.
    always_comb begin
        sum_x = {rx_d_reg[RES_W-1], rx_d_reg}
              + {{(RES_W+1-POS_W){ox_d_reg[POS_W-1]}}, ox_d_reg};
        sum_y = {ry_d_reg[RES_W-1], ry_d_reg}
              + {{(RES_W+1-POS_W){oy_d_reg[POS_W-1]}}, oy_d_reg};
        sat_x = (sum_x[RES_W:POS_W-1] != '0) && (sum_x[RES_W:POS_W-1] != '1);
        sat_y = (sum_y[RES_W:POS_W-1] != '0) && (sum_y[RES_W:POS_W-1] != '1);
        if (sat_x) begin
            cx_next = sum_x[RES_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            cx_next = sum_x[POS_W-1:0];
        end
        if (sat_y) begin
            cy_next = sum_y[RES_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            cy_next = sum_y[POS_W-1:0];
        end
        ovf_next = sat_x || sat_y;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (ctl_in.en) begin
            d_valid_reg   <= ctl_in.valid;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.en) begin
            rx_d_reg   <= rx_d_next;
            ry_d_reg   <= ry_d_next;
            ox_d_reg   <= data_in.ox;
            oy_d_reg   <= data_in.oy;
            head_d_reg <= data_in.heading;

            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            head_reg   <= head_d_reg;
            ovf_reg    <= ovf_next;
        end
    end

    assign valid_out = out_valid_reg;
    assign cx        = cx_reg;
    assign cy        = cy_reg;
    assign c_heading = head_reg;
    assign overflow  = ovf_reg;

endmodule
